FILE: hdl/yhsa_pkg.sv
package yhsa_pkg;

   localparam int MAX_LUMA_POINTS = 4;
   localparam int NUM_STAGES      = 6;

   // Register indexes, taken from address bits [4:2].
   localparam logic [2:0] REG_LUMA_POINTS = 3'd0;
   localparam logic [2:0] REG_LUMA_GAIN_0 = 3'd1;
   localparam logic [2:0] REG_LUMA_GAIN_1 = 3'd2;
   localparam logic [2:0] REG_LUMA_GAIN_2 = 3'd3;
   localparam logic [2:0] REG_LUMA_GAIN_3 = 3'd4;
   localparam logic [2:0] REG_CHROMA_COS  = 3'd5;
   localparam logic [2:0] REG_CHROMA_SIN  = 3'd6;

   localparam logic [2:0]  RESET_LUMA_POINTS = 3'd0;
   localparam logic [15:0] RESET_GAIN        = 16'd16384;
   localparam logic [15:0] RESET_CHROMA_COS  = 16'd4096;
   localparam logic [15:0] RESET_CHROMA_SIN  = 16'd0;

   // Segment widths for three and four points, and the segment spans.
   localparam int SEG_W3 = 256 / 2;
   localparam int SEG_W4 = 256 / 3;
   localparam logic [7:0] SPAN_FULL  = 8'd255;
   localparam logic [7:0] SPAN_3     = 8'(SEG_W3 - 1);
   localparam logic [7:0] SPAN_4     = 8'(SEG_W4 - 1);
   localparam logic [7:0] SPAN_4_END = 8'(255 - 2 * SEG_W4);
   localparam logic [7:0] SPAN_ONE   = 8'd1;

   // Reciprocals floor(2^24 / span), used for the quotient estimate.
   localparam int RECIP_SHIFT = 24;
   localparam logic [17:0] RECIP_FULL  = 18'((2 ** RECIP_SHIFT) / 255);
   localparam logic [17:0] RECIP_3     = 18'((2 ** RECIP_SHIFT) / (SEG_W3 - 1));
   localparam logic [17:0] RECIP_4     = 18'((2 ** RECIP_SHIFT) / (SEG_W4 - 1));
   localparam logic [17:0] RECIP_4_END = 18'((2 ** RECIP_SHIFT) / (255 - 2 * SEG_W4));

   typedef struct packed {
      logic [2:0]                             luma_points;
      logic [MAX_LUMA_POINTS-1:0][15:0]       luma_gain;
      logic signed [15:0]                     chroma_cos;
      logic signed [15:0]                     chroma_sin;
   } cfg_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
   } pipe_ctrl_type;

   function automatic logic [17:0] recip_of(input logic [7:0] span);
      logic [17:0] r;
      r = '0;
      if (span == SPAN_FULL) begin
         r = RECIP_FULL;
      end else if (span == SPAN_3) begin
         r = RECIP_3;
      end else if (span == SPAN_4) begin
         r = RECIP_4;
      end else if (span == SPAN_4_END) begin
         r = RECIP_4_END;
      end
      return r;
   endfunction

endpackage

FILE: hdl/yhsa_luma.sv
module yhsa_luma (
   input  logic                   clock,
   input  yhsa_pkg::pipe_ctrl_type ctrl,
   input  yhsa_pkg::cfg_type      cfg,
   input  logic [7:0]             luma_in,
   output logic [7:0]             luma_out
);

   // Stage 1: segment decode.
   logic [2:0]  n_eff;
   logic        s1_pass_in, s1_pass_ff;
   logic [7:0]  s1_y_in, s1_y_ff;
   logic [7:0]  s1_span_in, s1_span_ff;
   logic [7:0]  s1_off_in, s1_off_ff;
   logic [7:0]  s1_rem_in, s1_rem_ff;
   logic [15:0] s1_ga_in, s1_ga_ff;
   logic [15:0] s1_gb_in, s1_gb_ff;

   always_comb begin
      n_eff = (cfg.luma_points > 3'(yhsa_pkg::MAX_LUMA_POINTS)) ?
              3'(yhsa_pkg::MAX_LUMA_POINTS) : cfg.luma_points;
      s1_y_in    = luma_in;
      s1_pass_in = 1'b0;
      s1_span_in = yhsa_pkg::SPAN_ONE;
      s1_off_in  = '0;
      s1_ga_in   = cfg.luma_gain[0];
      s1_gb_in   = cfg.luma_gain[0];
      unique case (n_eff)
         3'd0: begin
            s1_pass_in = 1'b1;
         end
         3'd1: begin
            s1_span_in = yhsa_pkg::SPAN_ONE;
         end
         3'd2: begin
            s1_span_in = yhsa_pkg::SPAN_FULL;
            s1_off_in  = luma_in;
            s1_gb_in   = cfg.luma_gain[1];
         end
         3'd3: begin
            s1_span_in = yhsa_pkg::SPAN_3;
            if (luma_in >= 8'(yhsa_pkg::SEG_W3)) begin
               s1_off_in = luma_in - 8'(yhsa_pkg::SEG_W3);
               s1_ga_in  = cfg.luma_gain[1];
               s1_gb_in  = cfg.luma_gain[2];
            end else begin
               s1_off_in = luma_in;
               s1_gb_in  = cfg.luma_gain[1];
            end
         end
         3'd4: begin
            if (luma_in >= 8'(2 * yhsa_pkg::SEG_W4)) begin
               s1_span_in = yhsa_pkg::SPAN_4_END;
               s1_off_in  = luma_in - 8'(2 * yhsa_pkg::SEG_W4);
               s1_ga_in   = cfg.luma_gain[2];
               s1_gb_in   = cfg.luma_gain[3];
            end else if (luma_in >= 8'(yhsa_pkg::SEG_W4)) begin
               s1_span_in = yhsa_pkg::SPAN_4;
               s1_off_in  = luma_in - 8'(yhsa_pkg::SEG_W4);
               s1_ga_in   = cfg.luma_gain[1];
               s1_gb_in   = cfg.luma_gain[2];
            end else begin
               s1_span_in = yhsa_pkg::SPAN_4;
               s1_off_in  = luma_in;
               s1_gb_in   = cfg.luma_gain[1];
            end
         end
         default: begin
            s1_pass_in = 1'b1;
         end
      endcase
      s1_rem_in = s1_span_in - s1_off_in;
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[0]) begin
         s1_pass_ff <= s1_pass_in;
         s1_y_ff    <= s1_y_in;
         s1_span_ff <= s1_span_in;
         s1_off_ff  <= s1_off_in;
         s1_rem_ff  <= s1_rem_in;
         s1_ga_ff   <= s1_ga_in;
         s1_gb_ff   <= s1_gb_in;
      end
   end

   // Stage 2: the two weighted gains.
   logic        s2_pass_ff;
   logic [7:0]  s2_y_ff, s2_span_ff;
   logic [23:0] s2_pa_in, s2_pa_ff, s2_pb_in, s2_pb_ff;

   assign s2_pa_in = 24'(s1_ga_ff) * 24'(s1_rem_ff);
   assign s2_pb_in = 24'(s1_gb_ff) * 24'(s1_off_ff);

   always_ff @(posedge clock) begin
      if (ctrl.en[1]) begin
         s2_pass_ff <= s1_pass_ff;
         s2_y_ff    <= s1_y_ff;
         s2_span_ff <= s1_span_ff;
         s2_pa_ff   <= s2_pa_in;
         s2_pb_ff   <= s2_pb_in;
      end
   end

   // Stage 3: interpolated gain, scaled by the span (fits 24 bits).
   logic        s3_pass_ff;
   logic [7:0]  s3_y_ff, s3_span_ff;
   logic [23:0] s3_g_in, s3_g_ff;

   assign s3_g_in = s2_pa_ff + s2_pb_ff;

   always_ff @(posedge clock) begin
      if (ctrl.en[2]) begin
         s3_pass_ff <= s2_pass_ff;
         s3_y_ff    <= s2_y_ff;
         s3_span_ff <= s2_span_ff;
         s3_g_ff    <= s3_g_in;
      end
   end

   // Stage 4: numerator with half a span of rounding, reduced by 2^14.
   logic        s4_pass_ff;
   logic [7:0]  s4_y_ff, s4_span_ff;
   logic [32:0] s4_num;
   logic [18:0] s4_m_in, s4_m_ff;

   assign s4_num  = 33'(s3_y_ff) * 33'(s3_g_ff) + {12'd0, s3_span_ff, 13'd0};
   assign s4_m_in = s4_num[32:14];

   always_ff @(posedge clock) begin
      if (ctrl.en[3]) begin
         s4_pass_ff <= s3_pass_ff;
         s4_y_ff    <= s3_y_ff;
         s4_span_ff <= s3_span_ff;
         s4_m_ff    <= s4_m_in;
      end
   end

   // Stage 5: quotient estimate by reciprocal; it is exact or one short.
   logic        s5_pass_ff;
   logic [7:0]  s5_y_ff, s5_span_ff;
   logic        s5_over_in, s5_over_ff;
   logic [33:0] s5_prod;
   logic [7:0]  s5_q_in, s5_q_ff;
   logic [15:0] s5_m_ff;

   assign s5_over_in = s4_m_ff >= {3'd0, s4_span_ff, 8'd0};
   assign s5_prod    = 34'(s4_m_ff[15:0]) * 34'(yhsa_pkg::recip_of(s4_span_ff));
   assign s5_q_in    = (s4_span_ff == yhsa_pkg::SPAN_ONE) ? s4_m_ff[7:0] :
                       s5_prod[yhsa_pkg::RECIP_SHIFT +: 8];

   always_ff @(posedge clock) begin
      if (ctrl.en[4]) begin
         s5_pass_ff <= s4_pass_ff;
         s5_y_ff    <= s4_y_ff;
         s5_span_ff <= s4_span_ff;
         s5_over_ff <= s5_over_in;
         s5_q_ff    <= s5_q_in;
         s5_m_ff    <= s4_m_ff[15:0];
      end
   end

   // Stage 6: remainder correction and clamp.
   logic [15:0] s6_rem;
   logic [7:0]  s6_q;
   logic [7:0]  s6_out_in, s6_out_ff;

   always_comb begin
      s6_rem = s5_m_ff - 16'(s5_q_ff) * 16'(s5_span_ff);
      s6_q   = (s6_rem >= 16'(s5_span_ff)) ? s5_q_ff + 8'd1 : s5_q_ff;
      priority if (s5_pass_ff) begin
         s6_out_in = s5_y_ff;
      end else if (s5_over_ff) begin
         s6_out_in = 8'd255;
      end else begin
         s6_out_in = s6_q;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[5]) begin
         s6_out_ff <= s6_out_in;
      end
   end

   assign luma_out = s6_out_ff;

endmodule

FILE: hdl/yhsa_chroma.sv
module yhsa_chroma (
   input  logic                   clock,
   input  yhsa_pkg::pipe_ctrl_type ctrl,
   input  yhsa_pkg::cfg_type      cfg,
   input  logic [7:0]             cb_in,
   input  logic [7:0]             cr_in,
   output logic [7:0]             cb_out,
   output logic [7:0]             cr_out
);

   function automatic logic [7:0] round_clamp(input logic signed [25:0] sum);
      logic signed [25:0] biased;
      logic signed [14:0] val;
      logic [7:0]         res;
      biased = sum + 26'sd2048;
      val    = {biased[25], biased[25:12]} + 15'sd128;
      if (val < 15'sd0) begin
         res = 8'd0;
      end else if (val > 15'sd255) begin
         res = 8'd255;
      end else begin
         res = val[7:0];
      end
      return res;
   endfunction

   // Stage 1: remove the offset.
   logic signed [8:0] s1_u_in, s1_u_ff, s1_v_in, s1_v_ff;

   assign s1_u_in = $signed({1'b0, cb_in}) - 9'sd128;
   assign s1_v_in = $signed({1'b0, cr_in}) - 9'sd128;

   always_ff @(posedge clock) begin
      if (ctrl.en[0]) begin
         s1_u_ff <= s1_u_in;
         s1_v_ff <= s1_v_in;
      end
   end

   // Stage 2: the four products.
   logic signed [24:0] s2_uc_in, s2_uc_ff, s2_vs_in, s2_vs_ff;
   logic signed [24:0] s2_vc_in, s2_vc_ff, s2_us_in, s2_us_ff;

   assign s2_uc_in = 25'(s1_u_ff) * 25'(cfg.chroma_cos);
   assign s2_vs_in = 25'(s1_v_ff) * 25'(cfg.chroma_sin);
   assign s2_vc_in = 25'(s1_v_ff) * 25'(cfg.chroma_cos);
   assign s2_us_in = 25'(s1_u_ff) * 25'(cfg.chroma_sin);

   always_ff @(posedge clock) begin
      if (ctrl.en[1]) begin
         s2_uc_ff <= s2_uc_in;
         s2_vs_ff <= s2_vs_in;
         s2_vc_ff <= s2_vc_in;
         s2_us_ff <= s2_us_in;
      end
   end

   // Stage 3: sums, rounding and clamp; later stages only keep it in step.
   logic [7:0] s3_cb_in, s3_cr_in;
   logic [yhsa_pkg::NUM_STAGES-1:2][7:0] cb_ff, cr_ff;

   assign s3_cb_in = round_clamp(26'(s2_uc_ff) + 26'(s2_vs_ff));
   assign s3_cr_in = round_clamp(26'(s2_vc_ff) - 26'(s2_us_ff));

   always_ff @(posedge clock) begin
      if (ctrl.en[2]) begin
         cb_ff[2] <= s3_cb_in;
         cr_ff[2] <= s3_cr_in;
      end
      for (int k = 3; k < yhsa_pkg::NUM_STAGES; k++) begin
         if (ctrl.en[k]) begin
            cb_ff[k] <= cb_ff[k-1];
            cr_ff[k] <= cr_ff[k-1];
         end
      end
   end

   assign cb_out = cb_ff[yhsa_pkg::NUM_STAGES-1];
   assign cr_out = cr_ff[yhsa_pkg::NUM_STAGES-1];

endmodule

FILE: hdl/yuv_luma_curve_hue_sat_adjust.sv
// Each accepted item passes through the pipeline stages to the rsp side.
// Throughput: one item per cycle while rsp_tready is high; the six pipeline stages
// each hold a valid bit and a stalled stage only holds up the stages behind it.
// Reset: synchronous and active high; it empties the pipeline and returns the
// registers to luma_points 0, gains 16384, chroma_cos 4096, chroma_sin 0.
module yuv_luma_curve_hue_sat_adjust (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // luma_in [7:0], cb_in [15:8], cr_in [23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // luma_out [7:0], cb_out [15:8], cr_out [23:16]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int NS = yhsa_pkg::NUM_STAGES;

   yhsa_pkg::cfg_type       cfg_ff, cfg_in;
   yhsa_pkg::pipe_ctrl_type ctrl;
   logic [NS-1:0]           valid_ff, valid_in;
   logic [2:0]              csr_index;
   logic                    csr_write;

   // Register file.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            yhsa_pkg::REG_LUMA_POINTS: cfg_in.luma_points  = csr_pwdata[2:0];
            yhsa_pkg::REG_LUMA_GAIN_0: cfg_in.luma_gain[0] = csr_pwdata[15:0];
            yhsa_pkg::REG_LUMA_GAIN_1: cfg_in.luma_gain[1] = csr_pwdata[15:0];
            yhsa_pkg::REG_LUMA_GAIN_2: cfg_in.luma_gain[2] = csr_pwdata[15:0];
            yhsa_pkg::REG_LUMA_GAIN_3: cfg_in.luma_gain[3] = csr_pwdata[15:0];
            yhsa_pkg::REG_CHROMA_COS:  cfg_in.chroma_cos   = csr_pwdata[15:0];
            yhsa_pkg::REG_CHROMA_SIN:  cfg_in.chroma_sin   = csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.luma_points <= yhsa_pkg::RESET_LUMA_POINTS;
         for (int i = 0; i < yhsa_pkg::MAX_LUMA_POINTS; i++) begin
            cfg_ff.luma_gain[i] <= yhsa_pkg::RESET_GAIN;
         end
         cfg_ff.chroma_cos <= yhsa_pkg::RESET_CHROMA_COS;
         cfg_ff.chroma_sin <= yhsa_pkg::RESET_CHROMA_SIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (csr_index)
         yhsa_pkg::REG_LUMA_POINTS: csr_prdata = {29'd0, cfg_ff.luma_points};
         yhsa_pkg::REG_LUMA_GAIN_0: csr_prdata = {16'd0, cfg_ff.luma_gain[0]};
         yhsa_pkg::REG_LUMA_GAIN_1: csr_prdata = {16'd0, cfg_ff.luma_gain[1]};
         yhsa_pkg::REG_LUMA_GAIN_2: csr_prdata = {16'd0, cfg_ff.luma_gain[2]};
         yhsa_pkg::REG_LUMA_GAIN_3: csr_prdata = {16'd0, cfg_ff.luma_gain[3]};
         yhsa_pkg::REG_CHROMA_COS:  csr_prdata = 32'(cfg_ff.chroma_cos);
         yhsa_pkg::REG_CHROMA_SIN:  csr_prdata = 32'(cfg_ff.chroma_sin);
         default:                   csr_prdata = 32'd0;
      endcase
   end

   // A stage may load when it is empty or when the stage after it moves on.
   always_comb begin
      ctrl.en[NS-1] = !valid_ff[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         ctrl.en[k] = !valid_ff[k] || ctrl.en[k+1];
      end
      valid_in = valid_ff;
      valid_in[0] = ctrl.en[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < NS; k++) begin
         if (ctrl.en[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = ctrl.en[0];
   assign rsp_tvalid = valid_ff[NS-1];

   yhsa_luma u_luma (
      .clock    (clock),
      .ctrl     (ctrl),
      .cfg      (cfg_ff),
      .luma_in  (req_tdata[7:0]),
      .luma_out (rsp_tdata[7:0])
   );

   yhsa_chroma u_chroma (
      .clock  (clock),
      .ctrl   (ctrl),
      .cfg    (cfg_ff),
      .cb_in  (req_tdata[15:8]),
      .cr_in  (req_tdata[23:16]),
      .cb_out (rsp_tdata[15:8]),
      .cr_out (rsp_tdata[23:16])
   );

   // A full pipeline facing a stalled output must refuse new items.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while the pipeline was full and stalled");

   // An accepted item occupies the first stage on the next cycle.
   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[0])
      else $error("accepted item did not enter the first stage");

   // The input side only stalls when the first stage is occupied.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> valid_ff[0])
      else $error("input stalled with an empty first stage");

endmodule

FILE: test/yuv_luma_curve_hue_sat_adjust_test.sv
`timescale 1ns / 100ps

class pixel_scoreboard;
   logic [2:0]         luma_points;
   logic [15:0]        luma_gain [yhsa_pkg::MAX_LUMA_POINTS];
   logic signed [15:0] chroma_cos;
   logic signed [15:0] chroma_sin;
   logic [23:0]        expected_pixels [$];
   int                 errors;

   function new();
      luma_points = yhsa_pkg::RESET_LUMA_POINTS;
      foreach (luma_gain[i]) luma_gain[i] = yhsa_pkg::RESET_GAIN;
      chroma_cos = yhsa_pkg::RESET_CHROMA_COS;
      chroma_sin = yhsa_pkg::RESET_CHROMA_SIN;
      errors = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
         yhsa_pkg::REG_LUMA_POINTS: luma_points = value[2:0];
         yhsa_pkg::REG_LUMA_GAIN_0: luma_gain[0] = value[15:0];
         yhsa_pkg::REG_LUMA_GAIN_1: luma_gain[1] = value[15:0];
         yhsa_pkg::REG_LUMA_GAIN_2: luma_gain[2] = value[15:0];
         yhsa_pkg::REG_LUMA_GAIN_3: luma_gain[3] = value[15:0];
         yhsa_pkg::REG_CHROMA_COS:  chroma_cos = value[15:0];
         yhsa_pkg::REG_CHROMA_SIN:  chroma_sin = value[15:0];
         default: ;
      endcase
   endfunction

   // Piecewise-linear gain on luma, computed exactly as one division per pixel.
   function logic [7:0] luma_curve(logic [7:0] y);
      int unsigned       n;
      int unsigned       incr;
      int unsigned       seg;
      int unsigned       s;
      int unsigned       e;
      longint unsigned   yy;
      longint unsigned   d;
      longint unsigned   off;
      longint unsigned   ga;
      longint unsigned   gb;
      longint unsigned   q;
      n = luma_points;
      if (n > yhsa_pkg::MAX_LUMA_POINTS) n = yhsa_pkg::MAX_LUMA_POINTS;
      yy = y;
      if (n == 0) return y;
      if (n == 1) begin
         ga = luma_gain[0];
         q = (yy * ga + 8192) >> 14;
         return (q > 255) ? 8'd255 : q[7:0];
      end
      incr = 256 / (n - 1);
      seg = y / incr;
      if (seg > n - 2) seg = n - 2;
      s = seg * incr;
      e = (seg == n - 2) ? 255 : (seg + 1) * incr - 1;
      d = e - s;
      off = yy - s;
      ga = luma_gain[seg];
      gb = luma_gain[seg + 1];
      q = (yy * (ga * (d - off) + gb * off) + d * 8192) / (d * 16384);
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   function logic [7:0] chroma_round(longint sum);
      longint r;
      r = ((sum + 2048) >>> 12) + 128;
      if (r < 0) return 8'd0;
      if (r > 255) return 8'd255;
      return r[7:0];
   endfunction

   function logic [23:0] adjust_pixel(logic [23:0] pixel);
      longint u;
      longint v;
      longint c;
      longint s;
      logic [7:0] cb_adj;
      logic [7:0] cr_adj;
      u = longint'(pixel[15:8]) - 128;
      v = longint'(pixel[23:16]) - 128;
      c = chroma_cos;
      s = chroma_sin;
      cb_adj = chroma_round(u * c + v * s);
      cr_adj = chroma_round(v * c - u * s);
      return {cr_adj, cb_adj, luma_curve(pixel[7:0])};
   endfunction

   function void note_pixel(logic [23:0] pixel);
      expected_pixels.push_back(adjust_pixel(pixel));
   endfunction

   function void check_pixel(logic [23:0] got);
      logic [23:0] want;
      if (expected_pixels.size() == 0) begin
         $error("result item %h arrived with nothing expected", got);
         errors++;
         return;
      end
      want = expected_pixels.pop_front();
      if (got[7:0] !== want[7:0]) begin
         $error("luma_out: expected %0d, actual %0d", want[7:0], got[7:0]);
         errors++;
      end
      if (got[15:8] !== want[15:8]) begin
         $error("cb_out: expected %0d, actual %0d", want[15:8], got[15:8]);
         errors++;
      end
      if (got[23:16] !== want[23:16]) begin
         $error("cr_out: expected %0d, actual %0d", want[23:16], got[23:16]);
         errors++;
      end
   endfunction

   function int pending();
      return expected_pixels.size();
   endfunction
endclass

module yuv_luma_curve_hue_sat_adjust_test;

   localparam int         CYCLE_LIMIT   = 400000;
   localparam int         BATCHES       = 12;
   localparam int         BATCH_ITEMS   = 115;
   localparam logic [2:0] REG_UNUSED    = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;    // luma_in [7:0], cb_in [15:8], cr_in [23:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // luma_out [7:0], cb_out [15:8], cr_out [23:16]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int              sender_idle = 0;
   int              receiver_idle = 0;
   int              cycle_count = 0;
   pixel_scoreboard sb;

   yuv_luma_curve_hue_sat_adjust uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_idle);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_pixel(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_pixel(rsp_tdata);
      end
   end

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_pixel(input logic [7:0] y, input logic [7:0] cb, input logic [7:0] cr);
      while ($urandom_range(0, 99) < sender_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {cr, cb, y};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (yhsa_pkg::NUM_STAGES + 4) @(negedge clock);
   endtask

   // Returns with psel and penable low so that writes can follow each other.
   task automatic write_csr(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Upper data bits carry noise; only the register's own width should count.
   task automatic set_curve(input logic [2:0] points, input logic [15:0] g0,
                            input logic [15:0] g1, input logic [15:0] g2,
                            input logic [15:0] g3, input logic [15:0] c,
                            input logic [15:0] s);
      drain_pipeline();
      write_csr(yhsa_pkg::REG_LUMA_POINTS, {16'($urandom_range(0, 65535)), 13'd0, points});
      write_csr(yhsa_pkg::REG_LUMA_GAIN_0, {16'($urandom_range(0, 65535)), g0});
      write_csr(yhsa_pkg::REG_LUMA_GAIN_1, {16'($urandom_range(0, 65535)), g1});
      write_csr(yhsa_pkg::REG_LUMA_GAIN_2, {16'($urandom_range(0, 65535)), g2});
      write_csr(yhsa_pkg::REG_LUMA_GAIN_3, {16'($urandom_range(0, 65535)), g3});
      write_csr(yhsa_pkg::REG_CHROMA_COS, {16'($urandom_range(0, 65535)), c});
      write_csr(yhsa_pkg::REG_CHROMA_SIN, {16'($urandom_range(0, 65535)), s});
   endtask

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 4))
         0: return 16'd0;
         1: return 16'd65535;
         2: return yhsa_pkg::RESET_GAIN;
         3: return 16'(16384 + $urandom_range(0, 8192) - 4096);
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [15:0] pick_coeff();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'd0;
         3: return yhsa_pkg::RESET_CHROMA_COS;
         4: return 16'($urandom_range(0, 12000) - 6000);
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // A quarter of the samples sit near the chroma midpoint, where clamping is rarer.
   function automatic logic [7:0] pick_sample();
      if ($urandom_range(0, 3) == 0) return 8'(128 + $urandom_range(0, 16) - 8);
      return 8'($urandom_range(0, 255));
   endfunction

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Settings straight out of reset: luma passes, chroma is unchanged.
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd128, 8'd128, 8'd128);

      // Four points with extreme gains; pixels on the segment edges.
      set_curve(3'd4, 16'd0, 16'd65535, 16'd16384, 16'd65535, 16'h7fff, 16'h8000);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd84, 8'd255, 8'd0);
      send_pixel(8'd85, 8'd128, 8'd0);
      send_pixel(8'd169, 8'd0, 8'd128);
      send_pixel(8'd170, 8'd129, 8'd127);
      send_pixel(8'd255, 8'd255, 8'd255);

      // A point count above the maximum behaves as the maximum.
      set_curve(3'd7, 16'd65535, 16'd0, 16'd65535, 16'd0, 16'h8000, 16'h7fff);
      send_pixel(8'd86, 8'd0, 8'd0);
      send_pixel(8'd200, 8'd255, 8'd255);

      // One point; the write to the unused index must change nothing.
      set_curve(3'd1, 16'd65535, 16'd0, 16'd0, 16'd0, 16'd4096, 16'd0);
      write_csr(REG_UNUSED, 32'hffff_ffff);
      send_pixel(8'd255, 8'd128, 8'd128);
      send_pixel(8'd1, 8'd127, 8'd129);

      set_curve(3'd3, 16'd8192, 16'd32768, 16'd0, 16'd65535, 16'd4096, 16'd4096);
      send_pixel(8'd127, 8'd200, 8'd50);
      send_pixel(8'd128, 8'd50, 8'd200);

      set_curve(3'd2, 16'd0, 16'd65535, 16'd12345, 16'd54321, 16'd4096, 16'd0);
      send_pixel(8'd200, 8'd128, 8'd128);

      // Half a unit of chroma either side of the midpoint rounds up.
      set_curve(3'd0, 16'd16384, 16'd16384, 16'd16384, 16'd16384, 16'd2048, 16'd0);
      send_pixel(8'd77, 8'd129, 8'd127);
      send_pixel(8'd77, 8'd127, 8'd129);

      for (int b = 0; b < BATCHES; b++) begin
         set_curve(3'(b % 8), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                   pick_coeff(), pick_coeff());
         if ($urandom_range(0, 3) == 0) write_csr(REG_UNUSED, $urandom());
         if (b < BATCHES / 3) begin
            sender_idle = 11;
            receiver_idle = 87;
         end else if (b < 2 * BATCHES / 3) begin
            sender_idle = 87;
            receiver_idle = 11;
         end else begin
            sender_idle = 0;
            receiver_idle = 0;
         end
         repeat (BATCH_ITEMS) send_pixel(pick_sample(), pick_sample(), pick_sample());
      end

      sender_idle = 0;
      receiver_idle = 0;
      drain_pipeline();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/yhsa_pkg.sv
hdl/yhsa_luma.sv
hdl/yhsa_chroma.sv
hdl/yuv_luma_curve_hue_sat_adjust.sv
test/yuv_luma_curve_hue_sat_adjust_test.sv
